@@ sv/rhc_pkg.sv @@
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared types and constants for the RGB to HSV hexcone converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

  // Channel and quotient widths
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned QUO_W     = 8;
  localparam int unsigned DIV_STEPS = QUO_W;
  localparam int unsigned DIV_SHIFT = DIV_STEPS - 1;

  // Saturation divide: diff*255 over max
  localparam int unsigned SAT_NUM_W = 2 * CHAN_W;
  localparam int unsigned SAT_DVS_W = CHAN_W + DIV_SHIFT;

  // Hue divide: t*255 over 6*diff, t below 6*diff
  localparam int unsigned HUE_T_W   = CHAN_W + 3;
  localparam int unsigned HUE_NUM_W = HUE_T_W + CHAN_W;
  localparam int unsigned HUE_DVS_W = HUE_T_W + DIV_SHIFT;

  // Input transaction payload
  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } pix_in_t;

  // Output transaction payload
  typedef struct packed {
    logic [CHAN_W-1:0] hue_out;
    logic [CHAN_W-1:0] sat_out;
    logic [CHAN_W-1:0] val_out;
  } hsv_out_t;

  // Divider pipeline word: two restoring dividers side by side plus value
  typedef struct packed {
    logic [SAT_NUM_W-1:0] sat_rem;
    logic [SAT_DVS_W-1:0] sat_dvs;
    logic [QUO_W-1:0]     sat_quo;
    logic [HUE_NUM_W-1:0] hue_rem;
    logic [HUE_DVS_W-1:0] hue_dvs;
    logic [QUO_W-1:0]     hue_quo;
    logic [CHAN_W-1:0]    val;
  } div_pipe_t;

endpackage

@@ sv/rhc_front.sv @@
// ----------------------------------------------------------------------------
// rhc_front
// Three-stage front end: max/min and sector, hue offset and wrap, numerators
// and pre-shifted divisors for the two dividers.
// ----------------------------------------------------------------------------
module rhc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rhc_pkg::pix_in_t    in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rhc_pkg::div_pipe_t  out_data_o
);

  typedef enum logic [1:0] {
    SECT_RED   = 2'd0,
    SECT_GREEN = 2'd1,
    SECT_BLUE  = 2'd2
  } sector_e;

  // Handshake chain
  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic s1_ready, s2_ready, s3_ready;

  assign s3_ready   = !s3_valid_q || out_ready_i;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= in_valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
      if (s3_ready) s3_valid_q <= s2_valid_q;
    end
  end

  // Stage 1: max, min, sector and signed channel difference
  logic [rhc_pkg::CHAN_W-1:0] mx, mn;
  sector_e                    sect;
  logic signed [rhc_pkg::CHAN_W:0] delta;

  logic [rhc_pkg::CHAN_W-1:0]      s1_val_q, s1_diff_q;
  sector_e                         s1_sect_q;
  logic signed [rhc_pkg::CHAN_W:0] s1_delta_q;

  always_comb begin
    mx = in_data_i.red_in;
    mn = in_data_i.red_in;
    if (in_data_i.green_in > mx) mx = in_data_i.green_in;
    if (in_data_i.blue_in  > mx) mx = in_data_i.blue_in;
    if (in_data_i.green_in < mn) mn = in_data_i.green_in;
    if (in_data_i.blue_in  < mn) mn = in_data_i.blue_in;
    // red wins ties, then green
    priority if (in_data_i.red_in == mx) begin
      sect  = SECT_RED;
      delta = $signed({1'b0, in_data_i.green_in}) - $signed({1'b0, in_data_i.blue_in});
    end else if (in_data_i.green_in == mx) begin
      sect  = SECT_GREEN;
      delta = $signed({1'b0, in_data_i.blue_in}) - $signed({1'b0, in_data_i.red_in});
    end else begin
      sect  = SECT_BLUE;
      delta = $signed({1'b0, in_data_i.red_in}) - $signed({1'b0, in_data_i.green_in});
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_val_q   <= mx;
      s1_diff_q  <= mx - mn;
      s1_sect_q  <= sect;
      s1_delta_q <= delta;
    end
  end

  // Stage 2: t = offset*diff + delta, wrapped by 6*diff; saturation operands
  logic [rhc_pkg::HUE_T_W-1:0]      ofs_term, six_diff, t_wrap;
  logic signed [rhc_pkg::HUE_T_W:0] t_raw;

  logic [rhc_pkg::HUE_T_W-1:0]   s2_t_q, s2_hue_dvs_q;
  logic [rhc_pkg::SAT_NUM_W-1:0] s2_sat_num_q;
  logic [rhc_pkg::CHAN_W-1:0]    s2_sat_dvs_q, s2_val_q;

  always_comb begin
    unique case (s1_sect_q)
      SECT_GREEN: ofs_term = rhc_pkg::HUE_T_W'({s1_diff_q, 1'b0});
      SECT_BLUE:  ofs_term = rhc_pkg::HUE_T_W'({s1_diff_q, 2'b00});
      default:    ofs_term = '0;
    endcase
    six_diff = rhc_pkg::HUE_T_W'({s1_diff_q, 2'b00}) + rhc_pkg::HUE_T_W'({s1_diff_q, 1'b0});
    t_raw    = $signed({1'b0, ofs_term})
             + (rhc_pkg::HUE_T_W+1)'(s1_delta_q);
    if (t_raw < 0) begin
      t_wrap = rhc_pkg::HUE_T_W'(t_raw + $signed({1'b0, six_diff}));
    end else begin
      t_wrap = rhc_pkg::HUE_T_W'(t_raw);
    end
  end

  // Zero divisors become one: the numerator is zero then, giving a zero quotient
  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_ready) begin
      s2_t_q       <= t_wrap;
      s2_hue_dvs_q <= (s1_diff_q == '0) ? rhc_pkg::HUE_T_W'(1) : six_diff;
      s2_sat_num_q <= {s1_diff_q, 8'h00} - rhc_pkg::SAT_NUM_W'(s1_diff_q);
      s2_sat_dvs_q <= (s1_val_q == '0) ? rhc_pkg::CHAN_W'(1) : s1_val_q;
      s2_val_q     <= s1_val_q;
    end
  end

  // Stage 3: hue numerator t*255 and divisors aligned to the top quotient bit
  rhc_pkg::div_pipe_t s3_data_q;

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && s3_ready) begin
      s3_data_q.sat_rem <= s2_sat_num_q;
      s3_data_q.sat_dvs <= rhc_pkg::SAT_DVS_W'(s2_sat_dvs_q) << rhc_pkg::DIV_SHIFT;
      s3_data_q.sat_quo <= '0;
      s3_data_q.hue_rem <= {s2_t_q, 8'h00} - rhc_pkg::HUE_NUM_W'(s2_t_q);
      s3_data_q.hue_dvs <= rhc_pkg::HUE_DVS_W'(s2_hue_dvs_q) << rhc_pkg::DIV_SHIFT;
      s3_data_q.hue_quo <= '0;
      s3_data_q.val     <= s2_val_q;
    end
  end

  assign out_valid_o = s3_valid_q;
  assign out_data_o  = s3_data_q;

endmodule

@@ sv/rhc_div_step.sv @@
// ----------------------------------------------------------------------------
// rhc_div_step
// One registered restoring-division step for both the saturation and the hue
// divider: one quotient bit each, divisor shifted down for the next step.
// ----------------------------------------------------------------------------
module rhc_div_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rhc_pkg::div_pipe_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rhc_pkg::div_pipe_t  out_data_o
);

  logic               valid_q;
  rhc_pkg::div_pipe_t data_q, data_d;
  logic               sat_ge, hue_ge;

  assign in_ready_o = !valid_q || out_ready_i;

  // Trial subtract on both lanes
  always_comb begin
    sat_ge = in_data_i.sat_rem >= rhc_pkg::SAT_NUM_W'(in_data_i.sat_dvs);
    hue_ge = in_data_i.hue_rem >= rhc_pkg::HUE_NUM_W'(in_data_i.hue_dvs);

    data_d         = in_data_i;
    data_d.sat_dvs = in_data_i.sat_dvs >> 1;
    data_d.hue_dvs = in_data_i.hue_dvs >> 1;
    data_d.sat_quo = {in_data_i.sat_quo[rhc_pkg::QUO_W-2:0], sat_ge};
    data_d.hue_quo = {in_data_i.hue_quo[rhc_pkg::QUO_W-2:0], hue_ge};
    if (sat_ge) data_d.sat_rem = in_data_i.sat_rem - rhc_pkg::SAT_NUM_W'(in_data_i.sat_dvs);
    if (hue_ge) data_d.hue_rem = in_data_i.hue_rem - rhc_pkg::HUE_NUM_W'(in_data_i.hue_dvs);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

@@ sv/rgb_to_hsv_converter.sv @@
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// 8-bit RGB to hexcone HSV, fully pipelined, one pixel per clock while out_ready_i is high.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+----------------------------
//  in      | input     | in_valid_i/in_ready_o | in_data_i  (pix_in_t)
//  out     | output    | out_valid_o/out_ready_i | out_data_o (hsv_out_t)
//
//  One transaction per cycle while out_ready_i is high, through three front
//  stages and eight restoring-divider steps, one quotient bit per step.
//  Every stage carries its own valid bit and ready is chained stage by stage,
//  so bubbles close up under a stall and no transaction is lost or repeated.
//  Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rhc_pkg::pix_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rhc_pkg::hsv_out_t out_data_o
);

  logic               step_valid [rhc_pkg::DIV_STEPS+1];
  logic               step_ready [rhc_pkg::DIV_STEPS+1];
  rhc_pkg::div_pipe_t step_data  [rhc_pkg::DIV_STEPS+1];

  // Front end: max/min, hue offset, numerators and divisors
  rhc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (step_valid[0]),
    .out_ready_i (step_ready[0]),
    .out_data_o  (step_data[0])
  );

  // Divider chain, MSB of the quotient first
  for (genvar i = 0; i < rhc_pkg::DIV_STEPS; i++) begin : g_div
    rhc_div_step u_step (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (step_valid[i]),
      .in_ready_o  (step_ready[i]),
      .in_data_i   (step_data[i]),
      .out_valid_o (step_valid[i+1]),
      .out_ready_i (step_ready[i+1]),
      .out_data_o  (step_data[i+1])
    );
  end

  // Output transaction straight from the last step register
  assign out_valid_o = step_valid[rhc_pkg::DIV_STEPS];
  assign step_ready[rhc_pkg::DIV_STEPS] = out_ready_i;

  assign out_data_o.hue_out = step_data[rhc_pkg::DIV_STEPS].hue_quo;
  assign out_data_o.sat_out = step_data[rhc_pkg::DIV_STEPS].sat_quo;
  assign out_data_o.val_out = step_data[rhc_pkg::DIV_STEPS].val;

endmodule
